[hw/rtl/lmsp_pkg.sv]
// Shared types and constants for the LED matrix scan/PWM driver.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lmsp_pkg;

    localparam int DEF_PANEL_WIDTH = 32;
    localparam int DEF_ROW_PAIRS   = 16;
    localparam int DEF_PWM_PHASES  = 8;

    localparam int ACTION_W   = 2;
    localparam int COORD_W    = 5;
    localparam int LEVEL_W    = 4;
    localparam int PIX_W      = 3 * LEVEL_W;
    localparam int ROW_ADDR_W = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_FLASH = 2'd2,
        ACT_SCAN  = 2'd3
    } action_t;

    typedef enum logic {
        KIND_COLUMN = 1'b0,
        KIND_LATCH  = 1'b1
    } item_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic set_wr;       // write the accepted pixel into the back frame
        logic fill_load;    // capture the clear level
        logic init_wr;      // zero both frames at the sweep address
        logic fill_wr;      // write the clear level at the sweep address
        logic copy_rd;      // read back frame at the sweep address for flash
        logic issue_col;    // read one column pair into the pipeline
        logic issue_latch;  // push the latch beat and advance row/phase
    } lmsp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic col_last;
        logic s1_free;
    } lmsp_status_t;

    function automatic logic lit(input logic [LEVEL_W-1:0] level,
                                 input logic [LEVEL_W-1:0] thr);
        return level > thr;
    endfunction

endpackage

[hw/rtl/led_matrix_scan_pwm.sv]
// Top level of the double-buffered two-half-scan LED matrix driver.
// Depends on lmsp_pkg, lmsp_ctrl and lmsp_datapath.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid / s_ready   action, col_x, row_y, levels, fill_level
//   m_       out        m_valid / m_ready   item_kind, six color bits, row_address,
//                                           last_of_row
//
// A scan reads one column pair per cycle through the two display read ports while
// the m_ channel does not stall, then issues the latch. Clear and flash sweep the
// frame memory one word a cycle over 2^(clog2(2*ROW_PAIRS) + clog2(PANEL_WIDTH))
// words (1024 by default). After reset a clearing pass over every word zeroes
// both frames; s_ready stays low until it ends. A stalled m_ channel holds the
// output register and stops the column reads.
`timescale 1ns / 1ps

module led_matrix_scan_pwm
    import lmsp_pkg::*;
#(
    parameter int PANEL_WIDTH = DEF_PANEL_WIDTH,
    parameter int ROW_PAIRS   = DEF_ROW_PAIRS,
    parameter int PWM_PHASES  = DEF_PWM_PHASES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ACTION_W-1:0]   s_action,
    input  logic [COORD_W-1:0]    s_col_x,
    input  logic [COORD_W-1:0]    s_row_y,
    input  logic [LEVEL_W-1:0]    s_red_level,
    input  logic [LEVEL_W-1:0]    s_green_level,
    input  logic [LEVEL_W-1:0]    s_blue_level,
    input  logic [LEVEL_W-1:0]    s_fill_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_item_kind,
    output logic                  m_red_top,
    output logic                  m_green_top,
    output logic                  m_blue_top,
    output logic                  m_red_bottom,
    output logic                  m_green_bottom,
    output logic                  m_blue_bottom,
    output logic [ROW_ADDR_W-1:0] m_row_address,
    output logic                  m_last_of_row
);

    lmsp_cmd_t    cmd;
    lmsp_status_t status;

    lmsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .status   (status),
        .s_ready  (s_ready),
        .cmd      (cmd)
    );

    lmsp_datapath #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .ROW_PAIRS   (ROW_PAIRS),
        .PWM_PHASES  (PWM_PHASES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_col_x        (s_col_x),
        .s_row_y        (s_row_y),
        .s_red_level    (s_red_level),
        .s_green_level  (s_green_level),
        .s_blue_level   (s_blue_level),
        .s_fill_level   (s_fill_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item_kind    (m_item_kind),
        .m_red_top      (m_red_top),
        .m_green_top    (m_green_top),
        .m_blue_top     (m_blue_top),
        .m_red_bottom   (m_red_bottom),
        .m_green_bottom (m_green_bottom),
        .m_blue_bottom  (m_blue_bottom),
        .m_row_address  (m_row_address),
        .m_last_of_row  (m_last_of_row)
    );

endmodule

[hw/rtl/lmsp_ctrl.sv]
// Sequencing state machine for the LED matrix driver: clearing pass, fill,
// flash copy and row scan. Depends on lmsp_pkg.
`timescale 1ns / 1ps

module lmsp_ctrl
    import lmsp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [ACTION_W-1:0] s_action,
    input  lmsp_status_t        status,
    output logic                s_ready,
    output lmsp_cmd_t           cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_COPY,
        ST_SCAN_COL,
        ST_SCAN_LATCH
    } state_t;

    state_t state_reg;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_ready && s_valid;

    always_comb begin
        cmd             = '0;
        cmd.set_wr      = accept && (s_action == ACT_SET);
        cmd.fill_load   = accept && (s_action == ACT_CLEAR);
        cmd.init_wr     = (state_reg == ST_INIT);
        cmd.fill_wr     = (state_reg == ST_FILL);
        cmd.copy_rd     = (state_reg == ST_COPY);
        cmd.issue_col   = (state_reg == ST_SCAN_COL) && status.s1_free;
        cmd.issue_latch = (state_reg == ST_SCAN_LATCH) && status.s1_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            case (state_reg)
                ST_INIT: begin
                    if (status.sweep_last) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        case (s_action)
                            ACT_CLEAR: state_reg <= ST_FILL;
                            ACT_FLASH: state_reg <= ST_COPY;
                            ACT_SCAN:  state_reg <= ST_SCAN_COL;
                            default:   state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_FILL, ST_COPY: begin
                    if (status.sweep_last) state_reg <= ST_IDLE;
                end
                ST_SCAN_COL: begin
                    if (cmd.issue_col && status.col_last) state_reg <= ST_SCAN_LATCH;
                end
                ST_SCAN_LATCH: begin
                    if (status.s1_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_INIT;
            endcase
        end
    end

endmodule

[hw/rtl/lmsp_datapath.sv]
// Frame memories, sweep and column counters, PWM threshold and the two-stage
// result pipeline of the LED matrix driver. Depends on lmsp_pkg.
`timescale 1ns / 1ps

module lmsp_datapath
    import lmsp_pkg::*;
#(
    parameter int PANEL_WIDTH = DEF_PANEL_WIDTH,
    parameter int ROW_PAIRS   = DEF_ROW_PAIRS,
    parameter int PWM_PHASES  = DEF_PWM_PHASES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lmsp_cmd_t             cmd,
    output lmsp_status_t          status,
    input  logic [COORD_W-1:0]    s_col_x,
    input  logic [COORD_W-1:0]    s_row_y,
    input  logic [LEVEL_W-1:0]    s_red_level,
    input  logic [LEVEL_W-1:0]    s_green_level,
    input  logic [LEVEL_W-1:0]    s_blue_level,
    input  logic [LEVEL_W-1:0]    s_fill_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_item_kind,
    output logic                  m_red_top,
    output logic                  m_green_top,
    output logic                  m_blue_top,
    output logic                  m_red_bottom,
    output logic                  m_green_bottom,
    output logic                  m_blue_bottom,
    output logic [ROW_ADDR_W-1:0] m_row_address,
    output logic                  m_last_of_row
);

    localparam int CB        = $clog2(PANEL_WIDTH);
    localparam int RB        = $clog2(2 * ROW_PAIRS);
    localparam int RPB       = $clog2(ROW_PAIRS);
    localparam int PB        = $clog2(PWM_PHASES);
    localparam int AW        = RB + CB;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int CMP_W     = 8;

    logic [PIX_W-1:0] back_mem [MEM_DEPTH];
    logic [PIX_W-1:0] disp_mem [MEM_DEPTH];

    logic [AW-1:0]      sweep_addr_reg;
    logic [CB-1:0]      col_reg;
    logic [RPB-1:0]     row_reg;
    logic [PB-1:0]      phase_reg;
    logic [LEVEL_W-1:0] fill_reg;

    logic [PIX_W-1:0]   back_rd_reg;
    logic [AW-1:0]      cp_addr_reg;
    logic               cp_valid_reg;

    logic               s1_valid_reg;
    logic               s1_kind_reg;
    logic [RPB-1:0]     s1_row_reg;
    logic [PIX_W-1:0]   top_rd_reg;
    logic [PIX_W-1:0]   bot_rd_reg;

    logic               m_valid_reg;
    logic               m_item_kind_reg;
    logic [5:0]         m_bits_reg;
    logic [ROW_ADDR_W-1:0] m_row_address_reg;
    logic               m_last_reg;

    logic               adv2;
    logic               set_in_range;
    logic [AW-1:0]      set_addr;
    logic [AW-1:0]      top_addr;
    logic [AW-1:0]      bot_addr;
    logic [RB-1:0]      bot_row;
    logic [PB-1:0]      thr_rev;
    logic [LEVEL_W-1:0] thr;
    logic [PIX_W-1:0]   fill_pix;
    logic               sweep_step;

    assign adv2       = !m_valid_reg || m_ready;
    assign sweep_step = cmd.init_wr || cmd.fill_wr || cmd.copy_rd;

    assign status.sweep_last = (sweep_addr_reg == AW'(MEM_DEPTH - 1));
    assign status.col_last   = (col_reg == CB'(PANEL_WIDTH - 1));
    assign status.s1_free    = !s1_valid_reg || adv2;

    assign set_in_range = (CMP_W'(s_col_x) < CMP_W'(PANEL_WIDTH))
                       && (CMP_W'(s_row_y) < CMP_W'(2 * ROW_PAIRS));
    assign set_addr = {RB'(s_row_y), CB'(s_col_x)};
    assign bot_row  = RB'(row_reg) + RB'(ROW_PAIRS);
    assign top_addr = {RB'(row_reg), col_reg};
    assign bot_addr = {bot_row, col_reg};
    assign fill_pix = {fill_reg, fill_reg, fill_reg};

    // Threshold is the phase with its bits reversed
    always_comb begin
        thr_rev = '0;
        for (int i = 0; i < PB; i++) begin
            thr_rev[PB-1-i] = phase_reg[i];
        end
        thr = LEVEL_W'(thr_rev);
    end

    // Control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_addr_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            phase_reg      <= '0;
            cp_valid_reg   <= 1'b0;
        end else begin
            cp_valid_reg <= cmd.copy_rd;
            if (sweep_step) sweep_addr_reg <= sweep_addr_reg + 1'b1;
            if (cmd.issue_col) begin
                col_reg <= status.col_last ? '0 : col_reg + 1'b1;
            end
            if (cmd.issue_latch) begin
                if (row_reg == RPB'(ROW_PAIRS - 1)) begin
                    row_reg   <= '0;
                    phase_reg <= (phase_reg == PB'(PWM_PHASES - 1)) ? '0 : phase_reg + 1'b1;
                end else begin
                    row_reg <= row_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill_load) fill_reg <= s_fill_level;
        cp_addr_reg <= sweep_addr_reg;
    end

    // Back frame: one write port, one read port for the flash copy
    always_ff @(posedge aclk) begin
        if (cmd.init_wr) begin
            back_mem[sweep_addr_reg] <= '0;
        end else if (cmd.fill_wr) begin
            back_mem[sweep_addr_reg] <= fill_pix;
        end else if (cmd.set_wr && set_in_range) begin
            back_mem[set_addr] <= {s_blue_level, s_green_level, s_red_level};
        end
        back_rd_reg <= back_mem[sweep_addr_reg];
    end

    // Display frame: one write port, two read ports for the row pair
    always_ff @(posedge aclk) begin
        if (cmd.init_wr) begin
            disp_mem[sweep_addr_reg] <= '0;
        end else if (cp_valid_reg) begin
            disp_mem[cp_addr_reg] <= back_rd_reg;
        end
        if (cmd.issue_col) begin
            top_rd_reg <= disp_mem[top_addr];
            bot_rd_reg <= disp_mem[bot_addr];
        end
    end

    // Stage 1: read data or pending latch beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (cmd.issue_col || cmd.issue_latch) begin
            s1_valid_reg <= 1'b1;
        end else if (adv2) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue_col || cmd.issue_latch) begin
            s1_kind_reg <= cmd.issue_latch;
            s1_row_reg  <= row_reg;
        end
    end

    // Stage 2: output register, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv2) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && s1_valid_reg) begin
            m_item_kind_reg <= s1_kind_reg;
            if (s1_kind_reg == KIND_LATCH) begin
                m_bits_reg        <= '0;
                m_row_address_reg <= ROW_ADDR_W'(s1_row_reg);
                m_last_reg        <= 1'b1;
            end else begin
                m_bits_reg <= {lit(bot_rd_reg[11:8], thr), lit(bot_rd_reg[7:4], thr),
                               lit(bot_rd_reg[3:0], thr),  lit(top_rd_reg[11:8], thr),
                               lit(top_rd_reg[7:4], thr),  lit(top_rd_reg[3:0], thr)};
                m_row_address_reg <= '0;
                m_last_reg        <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_item_kind    = m_item_kind_reg;
    assign m_red_top      = m_bits_reg[0];
    assign m_green_top    = m_bits_reg[1];
    assign m_blue_top     = m_bits_reg[2];
    assign m_red_bottom   = m_bits_reg[3];
    assign m_green_bottom = m_bits_reg[4];
    assign m_blue_bottom  = m_bits_reg[5];
    assign m_row_address  = m_row_address_reg;
    assign m_last_of_row  = m_last_reg;

endmodule

[tb/sv/lmsp_tb_pkg.sv]
// Scoreboard for the LED matrix scan/PWM driver testbench: frame model and beat checks.
// Depends on lmsp_pkg for the action codes, item kinds and field widths.
`timescale 1ns / 1ps

package lmsp_tb_pkg;

    import lmsp_pkg::*;

    localparam int PANEL_ROWS = 2 * DEF_ROW_PAIRS;
    localparam int PHASE_W    = $clog2(DEF_PWM_PHASES);
    localparam int SHOW_LIMIT = 50;

    typedef struct packed {
        logic                  kind;
        logic                  red_top;
        logic                  green_top;
        logic                  blue_top;
        logic                  red_bottom;
        logic                  green_bottom;
        logic                  blue_bottom;
        logic [ROW_ADDR_W-1:0] row_address;
        logic                  last_of_row;
    } scan_beat_t;

    class frame_scan_scoreboard;
        bit [PIX_W-1:0]      back_pixels[PANEL_ROWS][DEF_PANEL_WIDTH];
        bit [PIX_W-1:0]      shown_pixels[PANEL_ROWS][DEF_PANEL_WIDTH];
        bit [ROW_ADDR_W-1:0] scan_row;
        bit [PHASE_W-1:0]    pwm_phase;
        scan_beat_t          expected_beats[$];
        int                  errors;

        // Threshold is the phase with its bits in reverse order.
        function bit [LEVEL_W-1:0] pwm_threshold();
            bit [LEVEL_W-1:0] thr;
            thr = '0;
            for (int i = 0; i < PHASE_W; i++) begin
                thr[PHASE_W-1-i] = pwm_phase[i];
            end
            return thr;
        endfunction

        function bit channel_lit(bit [PIX_W-1:0] px, int chan, bit [LEVEL_W-1:0] thr);
            return px[LEVEL_W*chan +: LEVEL_W] > thr;
        endfunction

        function void apply_action(action_t act, logic [COORD_W-1:0] x,
                                   logic [COORD_W-1:0] y, logic [LEVEL_W-1:0] red,
                                   logic [LEVEL_W-1:0] green, logic [LEVEL_W-1:0] blue,
                                   logic [LEVEL_W-1:0] fill);
            scan_beat_t       beat;
            bit [LEVEL_W-1:0] thr;
            int               top_row;
            int               bot_row;
            case (act)
                ACT_SET: begin
                    if (x < DEF_PANEL_WIDTH && y < PANEL_ROWS)
                        back_pixels[y][x] = {blue, green, red};
                end
                ACT_CLEAR: begin
                    foreach (back_pixels[r, c])
                        back_pixels[r][c] = {fill, fill, fill};
                end
                ACT_FLASH: begin
                    foreach (shown_pixels[r, c])
                        shown_pixels[r][c] = back_pixels[r][c];
                end
                ACT_SCAN: begin
                    thr     = pwm_threshold();
                    top_row = scan_row;
                    bot_row = top_row + DEF_ROW_PAIRS;
                    for (int c = 0; c < DEF_PANEL_WIDTH; c++) begin
                        beat              = '0;
                        beat.kind         = KIND_COLUMN;
                        beat.red_top      = channel_lit(shown_pixels[top_row][c], 0, thr);
                        beat.green_top    = channel_lit(shown_pixels[top_row][c], 1, thr);
                        beat.blue_top     = channel_lit(shown_pixels[top_row][c], 2, thr);
                        beat.red_bottom   = channel_lit(shown_pixels[bot_row][c], 0, thr);
                        beat.green_bottom = channel_lit(shown_pixels[bot_row][c], 1, thr);
                        beat.blue_bottom  = channel_lit(shown_pixels[bot_row][c], 2, thr);
                        expected_beats.push_back(beat);
                    end
                    beat             = '0;
                    beat.kind        = KIND_LATCH;
                    beat.row_address = scan_row;
                    beat.last_of_row = 1'b1;
                    expected_beats.push_back(beat);
                    // advance the phase once the last row pair has been latched
                    if (scan_row == DEF_ROW_PAIRS - 1) begin
                        scan_row  = '0;
                        pwm_phase = (pwm_phase == DEF_PWM_PHASES - 1) ? '0 : pwm_phase + 1'b1;
                    end else begin
                        scan_row = scan_row + 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [3:0] want, logic [3:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_beat(scan_beat_t got);
            scan_beat_t want;
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0t ns: beat expected none, actual kind %0d row %0d",
                             $time, got.kind, got.row_address);
                return;
            end
            want = expected_beats.pop_front();
            compare_field("item_kind", 4'(want.kind), 4'(got.kind));
            compare_field("red_top", 4'(want.red_top), 4'(got.red_top));
            compare_field("green_top", 4'(want.green_top), 4'(got.green_top));
            compare_field("blue_top", 4'(want.blue_top), 4'(got.blue_top));
            compare_field("red_bottom", 4'(want.red_bottom), 4'(got.red_bottom));
            compare_field("green_bottom", 4'(want.green_bottom), 4'(got.green_bottom));
            compare_field("blue_bottom", 4'(want.blue_bottom), 4'(got.blue_bottom));
            compare_field("row_address", 4'(want.row_address), 4'(got.row_address));
            compare_field("last_of_row", 4'(want.last_of_row), 4'(got.last_of_row));
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

endpackage

[tb/sv/tb.sv]
// Top-level testbench for led_matrix_scan_pwm: drives actions, checks every output beat.
// Depends on lmsp_pkg and lmsp_tb_pkg (scoreboard).
`timescale 1ns / 1ps

module tb;

    import lmsp_pkg::*;
    import lmsp_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 355;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT_BEAT = 2000;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [ACTION_W-1:0]   s_action      = '0;
    logic [COORD_W-1:0]    s_col_x       = '0;
    logic [COORD_W-1:0]    s_row_y       = '0;
    logic [LEVEL_W-1:0]    s_red_level   = '0;
    logic [LEVEL_W-1:0]    s_green_level = '0;
    logic [LEVEL_W-1:0]    s_blue_level  = '0;
    logic [LEVEL_W-1:0]    s_fill_level  = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_item_kind;
    logic                  m_red_top;
    logic                  m_green_top;
    logic                  m_blue_top;
    logic                  m_red_bottom;
    logic                  m_green_bottom;
    logic                  m_blue_bottom;
    logic [ROW_ADDR_W-1:0] m_row_address;
    logic                  m_last_of_row;

    frame_scan_scoreboard sb;
    int                   items_sent = 0;
    int                   rx_beats   = 0;
    int                   cycle_count = 0;
    bit                   tx_burst   = 1'b0;
    bit                   rx_burst   = 1'b0;
    bit                   hold_done  = 1'b0;

    led_matrix_scan_pwm dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_col_x        (s_col_x),
        .s_row_y        (s_row_y),
        .s_red_level    (s_red_level),
        .s_green_level  (s_green_level),
        .s_blue_level   (s_blue_level),
        .s_fill_level   (s_fill_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item_kind    (m_item_kind),
        .m_red_top      (m_red_top),
        .m_green_top    (m_green_top),
        .m_blue_top     (m_blue_top),
        .m_red_bottom   (m_red_bottom),
        .m_green_bottom (m_green_bottom),
        .m_blue_bottom  (m_blue_bottom),
        .m_row_address  (m_row_address),
        .m_last_of_row  (m_last_of_row)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sample the result channel at the rising edge.
    always @(posedge aclk) begin
        scan_beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind         = m_item_kind;
            got.red_top      = m_red_top;
            got.green_top    = m_green_top;
            got.blue_top     = m_blue_top;
            got.red_bottom   = m_red_bottom;
            got.green_bottom = m_green_bottom;
            got.blue_bottom  = m_blue_bottom;
            got.row_address  = m_row_address;
            got.last_of_row  = m_last_of_row;
            sb.check_beat(got);
            rx_beats++;
        end
    end

    function automatic logic [LEVEL_W-1:0] rand_level();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return LEVEL_W'($urandom_range(0, 15));
    endfunction

    // Offer one beat after a random gap; return once it is accepted.
    task automatic push_item(action_t act, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [LEVEL_W-1:0] red, logic [LEVEL_W-1:0] green,
                             logic [LEVEL_W-1:0] blue, logic [LEVEL_W-1:0] fill);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_action      <= act;
        s_col_x       <= x;
        s_row_y       <= y;
        s_red_level   <= red;
        s_green_level <= green;
        s_blue_level  <= blue;
        s_fill_level  <= fill;
        do @(posedge aclk); while (!s_ready);
        sb.apply_action(act, x, y, red, green, blue, fill);
        items_sent++;
    endtask

    task automatic push_random(action_t act);
        push_item(act, COORD_W'($urandom_range(0, 31)), COORD_W'($urandom_range(0, 31)),
                  rand_level(), rand_level(), rand_level(), rand_level());
    endtask

    // Receiver: random stalls per beat, bursts of back-to-back beats, one long hold.
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (!hold_done && rx_beats >= HOLD_AT_BEAT) begin
                hold_done = 1'b1;
                @(negedge aclk) m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if ($urandom_range(0, 99) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                @(negedge aclk) m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk) m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int n_sets;
        int n_scans;
        int pick;
        sb = new();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Scan of the empty display, then a few pixels at the corners and the halves.
        push_item(ACT_SCAN, '0, '0, '0, '0, '0, '0);
        push_item(ACT_SET, 5'd0, 5'd0, 4'd15, 4'd15, 4'd15, 4'd0);
        push_item(ACT_SET, 5'd31, 5'd17, 4'd8, 4'd0, 4'd15, 4'd0);
        push_item(ACT_SET, 5'd5, 5'd1, 4'd1, 4'd7, 4'd9, 4'd15);
        push_item(ACT_SET, 5'd31, 5'd15, 4'd15, 4'd8, 4'd1, 4'd0);
        push_item(ACT_SET, 5'd0, 5'd31, 4'd9, 4'd10, 4'd0, 4'd0);
        push_item(ACT_SET, 5'd16, 5'd16, 4'd2, 4'd4, 4'd6, 4'd0);
        // back frame changes must not show before a flash
        push_item(ACT_SCAN, 5'd31, 5'd31, 4'd15, 4'd15, 4'd15, 4'd15);
        push_item(ACT_FLASH, '0, '0, '0, '0, '0, '0);
        push_item(ACT_CLEAR, '0, '0, '0, '0, '0, 4'd15);
        // walk the remaining row pairs so the phase advances to the next threshold
        repeat (14) push_item(ACT_SCAN, '0, '0, '0, '0, '0, '0);
        push_item(ACT_FLASH, '0, '0, '0, '0, '0, '0);

        while (items_sent < 25 + RANDOM_ITEMS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                // noise: loose actions in any order
                repeat ($urandom_range(1, 4)) begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        push_random(ACT_CLEAR);
                    else if (pick == 1)
                        push_random(ACT_FLASH);
                    else if (pick < 10)
                        push_random(ACT_SET);
                    else
                        push_random(ACT_SCAN);
                end
            end else begin
                if ($urandom_range(0, 7) == 0)
                    push_random(ACT_CLEAR);
                n_sets  = $urandom_range(1, 8);
                n_scans = $urandom_range(1, 16);
                repeat (n_sets) push_random(ACT_SET);
                push_random(ACT_FLASH);
                repeat (n_scans) push_random(ACT_SCAN);
            end
        end
        @(negedge aclk) s_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
